### rtl/waveform_column_downsample_macros.svh
// Assertion macros for the column downsampler.
`ifndef WAVEFORM_COLUMN_DOWNSAMPLE_MACROS_SVH
`define WAVEFORM_COLUMN_DOWNSAMPLE_MACROS_SVH
`ifndef ASSERT_OFF
`define WCD_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define WCD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define WCD_ASSERT_IMPL(label, clk, rst_n, a, c)
`define WCD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/wcd_pkg.sv
`timescale 1ns / 1ps
package wcd_pkg;
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned DVD_W = 16;
  localparam int unsigned DVS_W = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  // division jobs of one column
  localparam logic [2:0] JOB_BACK_H  = 3'd0;
  localparam logic [2:0] JOB_FRONT_H = 3'd1;
  localparam logic [2:0] JOB_BACK_R  = 3'd2;
  localparam logic [2:0] JOB_BACK_G  = 3'd3;
  localparam logic [2:0] JOB_BACK_B  = 3'd4;
  localparam logic [2:0] JOB_FRONT_R = 3'd5;
  localparam logic [2:0] JOB_FRONT_G = 3'd6;
  localparam logic [2:0] JOB_FRONT_B = 3'd7;

  // register indexes
  localparam logic [2:0] REG_COLOR_MODE    = 3'd0;
  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd1;
  localparam logic [2:0] REG_COLUMN_COUNT  = 3'd2;
  localparam logic [2:0] REG_HEIGHT_PIXELS = 3'd3;
  localparam logic [2:0] REG_PEAK_LEVEL    = 3'd4;
endpackage

### rtl/wcd_div.sv
`timescale 1ns / 1ps
module wcd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wcd_pkg::DVD_W-1:0]  dividend,
  input  logic [wcd_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [wcd_pkg::DVD_W-1:0]  quotient,
  output logic [wcd_pkg::DVS_W-1:0]  remainder
);
  import wcd_pkg::*;

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fit;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fit   = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fit ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fit};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

### rtl/waveform_column_downsample.sv
`timescale 1ns / 1ps
// Column downsampler: each input word is one waveform sample; every bucket of
// samples yields one column word. A sample word that closes no bucket passes
// through the idle and update states; the first sample of a payload adds the
// stride division; a word that closes a bucket adds its divisions on the one
// shared bit-serial divider and then loads the output register: one division
// in mono mode, eight in rgb mode. The finished column sits in an output
// register, so the next sample is taken while it waits. An invalid register
// set drops samples. A write to one of the five registers restarts the
// payload, unless it falls in the update state.
module waveform_column_downsample (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // wave_byte[7:0], red_level[15:8], green_level[23:16], blue_level[31:24]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // column_number[11:0], back_bar[19:12], front_bar[27:20],
  // back_red[35:28], back_green[43:36], back_blue[51:44],
  // front_red[59:52], front_green[67:60], front_blue[75:68], zero[79:76]
  output logic [79:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import wcd_pkg::*;
  `include "waveform_column_downsample_macros.svh"

  // configuration
  logic        color_mode_r;
  logic [12:0] sample_count_r, column_count_r;
  logic [7:0]  height_r, peak_r;

  // bucket state
  logic [12:0] pos_r, col_r, limit_r, residue_r, stride_r, surplus_r;
  logic [23:0] strong_r, blue_r, in_word_r;
  logic        fresh_r;

  state_t      state_r, state_nxt;
  logic [2:0]  job_r;
  logic        launch_r, launch_nxt;
  logic [7:0]  res_r [8];

  logic [79:0] out_data_r;
  logic        out_valid_r, out_last_r;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  dvd, quo;
  logic [DVS_W-1:0]  dvs, rem;

  logic        cfg_ok, in_acc, load_out, col_last, upd_close, last_job;
  logic [7:0]  mag_s, mag_b, mag_new, mag_str, mul_a, mul_b, half;
  logic [15:0] prod;
  logic [23:0] smp;
  logic [12:0] pos_inc, res_sum;

  function automatic logic [7:0] mag3(input logic [23:0] s);
    logic [7:0] m;
    m = (s[23:16] > s[15:8]) ? s[23:16] : s[15:8];
    return (m > s[7:0]) ? m : s[7:0];
  endfunction

  assign cfg_ok = (sample_count_r >= 13'd1) && (sample_count_r <= 13'(MAX_SAMPLES))
               && (column_count_r >= 13'd1) && (column_count_r <= sample_count_r)
               && (height_r != 8'd0) && (!color_mode_r || (peak_r != 8'd0));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign smp     = color_mode_r ? in_word_r : {16'd0, in_word_r[7:0]};
  assign mag_s   = mag3(strong_r);
  assign mag_b   = mag3(blue_r);
  assign mag_new = mag3(smp);
  assign mag_str = mag3(strong_r);
  assign pos_inc = pos_r + 13'd1;
  assign upd_close = !(pos_inc < limit_r);
  assign last_job  = color_mode_r ? (job_r == JOB_FRONT_B) : (job_r == JOB_BACK_H);
  assign col_last  = !((col_r + 13'd1) < column_count_r);
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign res_sum   = residue_r + surplus_r;

  // operand select for the current division job, or the stride divisor
  always_comb begin
    mul_a = 8'd0;
    mul_b = height_r;
    half  = peak_r >> 1;
    dvs   = {5'd0, peak_r};
    case (job_r)
      JOB_BACK_H: begin
        if (color_mode_r) begin
          mul_a = mag_s;
        end else begin
          mul_a = {3'd0, strong_r[4:0]};
          half  = 8'd15;
          dvs   = 13'd31;
        end
      end
      JOB_FRONT_H: mul_a = blue_r[7:0];
      JOB_BACK_R: begin
        mul_a = strong_r[23:16]; mul_b = 8'd191; half = 8'd0; dvs = {5'd0, mag_s};
      end
      JOB_BACK_G: begin
        mul_a = strong_r[15:8];  mul_b = 8'd191; half = 8'd0; dvs = {5'd0, mag_s};
      end
      JOB_BACK_B: begin
        mul_a = strong_r[7:0];   mul_b = 8'd191; half = 8'd0; dvs = {5'd0, mag_s};
      end
      JOB_FRONT_R: begin
        mul_a = blue_r[23:16];   mul_b = 8'd255; half = 8'd0; dvs = {5'd0, mag_b};
      end
      JOB_FRONT_G: begin
        mul_a = blue_r[15:8];    mul_b = 8'd255; half = 8'd0; dvs = {5'd0, mag_b};
      end
      JOB_FRONT_B: begin
        mul_a = blue_r[7:0];     mul_b = 8'd255; half = 8'd0; dvs = {5'd0, mag_b};
      end
      default: ;
    endcase
    if (state_r == ST_STRIDE) begin
      dvs = column_count_r;
    end
  end

  assign prod = mul_a * mul_b + {8'd0, half};
  assign dvd  = (state_r == ST_STRIDE) ? {3'd0, sample_count_r} : prod;

  wcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && cfg_ok) begin
          state_nxt = (pos_r == 13'd0) ? ST_STRIDE : ST_UPDATE;
        end
      end
      ST_STRIDE: if (div_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = upd_close ? ST_DIV : ST_IDLE;
      ST_DIV:    if (div_done && last_job) state_nxt = ST_OUT;
      ST_OUT:    if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // register the launch of the next division so that its operands settle first
  always_comb begin
    launch_nxt = 1'b0;
    case (state_r)
      ST_IDLE:   launch_nxt = in_acc && cfg_ok && (pos_r == 13'd0);
      ST_UPDATE: launch_nxt = upd_close;
      ST_DIV:    launch_nxt = div_done && !last_job;
      default:   launch_nxt = 1'b0;
    endcase
  end

  // divider control
  always_comb begin
    div_start = 1'b0;
    case (state_r)
      ST_STRIDE, ST_DIV: div_start = launch_r;
      default:           div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      launch_r       <= 1'b0;
      job_r          <= JOB_BACK_H;
      color_mode_r   <= 1'b0;
      sample_count_r <= 13'd400;
      column_count_r <= 13'd400;
      height_r       <= 8'd32;
      peak_r         <= 8'd255;
      pos_r          <= '0;
      col_r          <= '0;
      limit_r        <= '0;
      residue_r      <= '0;
      stride_r       <= '0;
      surplus_r      <= '0;
      fresh_r        <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      // load a new column word, else drop the one taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_COLOR_MODE:    begin color_mode_r   <= cfg_data[0];   pos_r <= '0; end
          REG_SAMPLE_COUNT:  begin sample_count_r <= cfg_data;      pos_r <= '0; end
          REG_COLUMN_COUNT:  begin column_count_r <= cfg_data;      pos_r <= '0; end
          REG_HEIGHT_PIXELS: begin height_r       <= cfg_data[7:0]; pos_r <= '0; end
          REG_PEAK_LEVEL:    begin peak_r         <= cfg_data[7:0]; pos_r <= '0; end
          default: ;
        endcase
      end

      case (state_r)
        ST_STRIDE: begin
          if (div_done) begin
            stride_r  <= quo[12:0];
            surplus_r <= rem;
            limit_r   <= quo[12:0];
            residue_r <= rem;
            col_r     <= '0;
            fresh_r   <= 1'b1;
          end
        end
        ST_UPDATE: begin
          pos_r   <= pos_inc;
          fresh_r <= 1'b0;
          if (upd_close) begin
            job_r <= JOB_BACK_H;
          end
        end
        ST_DIV: begin
          if (div_done && !last_job) begin
            job_r <= job_r + 3'd1;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            fresh_r <= 1'b1;
            if (col_last) begin
              pos_r <= '0;
              col_r <= '0;
            end else begin
              col_r <= col_r + 13'd1;
              // advance the bucket end by stride plus carried remainder
              if (res_sum >= column_count_r) begin
                limit_r   <= limit_r + stride_r + 13'd1;
                residue_r <= res_sum - column_count_r;
              end else begin
                limit_r   <= limit_r + stride_r;
                residue_r <= res_sum;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers: sample word, bucket winners, job results, column word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (color_mode_r) begin
        in_word_r <= {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
      end else begin
        in_word_r <= {16'd0, in_tdata[7:0]};
      end
    end
    if (state_r == ST_UPDATE) begin
      if (fresh_r) begin
        strong_r <= smp;
        blue_r   <= smp;
      end else if (color_mode_r) begin
        if (mag_new > mag_str) strong_r <= smp;
        if (smp[7:0] > blue_r[7:0]) blue_r <= smp;
      end else if (smp[4:0] > strong_r[4:0]) begin
        strong_r <= smp;
      end
    end
    if ((state_r == ST_DIV) && div_done) begin
      if ((job_r == JOB_BACK_H) || (job_r == JOB_FRONT_H)) begin
        res_r[job_r] <= (quo > 16'd255) ? 8'd255 : quo[7:0];
      end else begin
        // black when the sample has zero magnitude
        res_r[job_r] <= (dvs == 13'd0) ? 8'd0 : quo[7:0];
      end
    end
    if (load_out) begin
      out_last_r <= col_last;
      if (color_mode_r) begin
        out_data_r <= {4'd0, res_r[7], res_r[6], res_r[5], res_r[4], res_r[3],
                       res_r[2], res_r[1], res_r[0], col_r[11:0]};
      end else if (strong_r[7:5] >= 3'd5) begin
        out_data_r <= {4'd0, 24'd0, 8'd244, 8'd246, 8'd116, 8'd0, res_r[0],
                       col_r[11:0]};
      end else begin
        out_data_r <= {4'd0, 24'd0, 8'd255, 8'd89, 8'd43, 8'd0, res_r[0],
                       col_r[11:0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `WCD_ASSERT_IMPL(a_div_in_div_state, clk, rst_n, div_start,
                   (state_r == ST_STRIDE) || (state_r == ST_DIV))
  `WCD_ASSERT_IMPL(a_last_col, clk, rst_n, out_valid_r && out_last_r,
                   {1'b0, out_data_r[11:0]} == (column_count_r - 13'd1))
  `WCD_ASSERT_NEXT(a_last_rewinds, clk, rst_n, load_out && col_last,
                   (pos_r == 13'd0) && out_tvalid)
endmodule

### tb/tb_waveform_column_downsample.sv
`timescale 1ns / 1ps
module tb_waveform_column_downsample;
  import wcd_pkg::*;

  typedef struct packed {
    logic [11:0] column_number;
    logic [7:0]  back_bar;
    logic [7:0]  front_bar;
    logic [7:0]  back_red;
    logic [7:0]  back_green;
    logic [7:0]  back_blue;
    logic [7:0]  front_red;
    logic [7:0]  front_green;
    logic [7:0]  front_blue;
    logic        last_column;
  } column_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  waveform_column_downsample dut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shadow copy of the register file.
  logic        mode_q;
  int unsigned nsamp_q, ncol_q, height_q, peak_q;
  // Shadow bucket state.
  int unsigned samp_pos, col_pos, bkt_end, bkt_rem, bkt_step, bkt_extra;
  logic [23:0] loud_smp, blue_smp;
  bit          bkt_open;

  logic [31:0] sample_queue[$];
  column_t     column_queue[$];
  int          mismatches;
  int          send_idle_pct, recv_idle_pct;
  int          hold_cycles;
  longint      cycle_count;
  logic        in_taken;

  function automatic int unsigned peak3(logic [23:0] s);
    int unsigned m;
    m = (s[23:16] > s[15:8]) ? s[23:16] : s[15:8];
    return (m > s[7:0]) ? m : s[7:0];
  endfunction

  function automatic logic [7:0] bar(int unsigned v, int unsigned r, int unsigned h);
    int unsigned q;
    q = (v * h + r / 2) / r;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [7:0] tint(logic [7:0] c, int unsigned lvl, int unsigned m);
    int unsigned q;
    q = m ? (c * lvl / m) : 0;
    return q[7:0];
  endfunction

  function automatic void advance_bucket();
    bkt_end += bkt_step;
    bkt_rem += bkt_extra;
    if (bkt_rem >= ncol_q) begin
      bkt_end += 1;
      bkt_rem -= ncol_q;
    end
  endfunction

  // Update shadow state with one sample; push the column it closes, if any.
  function automatic void predict_column(logic [31:0] w);
    logic [23:0] s;
    column_t     c;
    int unsigned m;
    if (nsamp_q < 1 || nsamp_q > MAX_SAMPLES || ncol_q < 1 || ncol_q > nsamp_q ||
        height_q < 1 || (mode_q && peak_q < 1))
      return;
    if (samp_pos == 0) begin
      bkt_step = nsamp_q / ncol_q;
      bkt_extra = nsamp_q - bkt_step * ncol_q;
      bkt_end = 0;
      bkt_rem = 0;
      col_pos = 0;
      advance_bucket();
      bkt_open = 1;
    end
    s = mode_q ? {w[15:8], w[23:16], w[31:24]} : {16'd0, w[7:0]};
    if (bkt_open) begin
      loud_smp = s;
      blue_smp = s;
      bkt_open = 0;
    end else if (mode_q) begin
      if (peak3(s) > peak3(loud_smp)) loud_smp = s;
      if (s[7:0] > blue_smp[7:0]) blue_smp = s;
    end else if (s[4:0] > loud_smp[4:0]) begin
      loud_smp = s;
    end
    samp_pos++;
    if (samp_pos < bkt_end) return;
    c = '0;
    c.column_number = col_pos[11:0];
    c.last_column = (col_pos + 1 >= ncol_q);
    if (mode_q) begin
      m = peak3(loud_smp);
      c.back_bar = bar(m, peak_q, height_q);
      c.front_bar = bar(blue_smp[7:0], peak_q, height_q);
      c.back_red = tint(loud_smp[23:16], 191, m);
      c.back_green = tint(loud_smp[15:8], 191, m);
      c.back_blue = tint(loud_smp[7:0], 191, m);
      m = peak3(blue_smp);
      c.front_red = tint(blue_smp[23:16], 255, m);
      c.front_green = tint(blue_smp[15:8], 255, m);
      c.front_blue = tint(blue_smp[7:0], 255, m);
    end else begin
      c.back_bar = bar(loud_smp[4:0], 31, height_q);
      if (loud_smp[7:5] >= 5) begin
        c.back_red = 8'd116; c.back_green = 8'd246; c.back_blue = 8'd244;
      end else begin
        c.back_red = 8'd43; c.back_green = 8'd89; c.back_blue = 8'd255;
      end
    end
    if (c.last_column) begin
      samp_pos = 0;
      col_pos = 0;
    end else begin
      col_pos++;
      advance_bucket();
    end
    bkt_open = 1;
    column_queue.push_back(c);
  endfunction

  // Input side: predict on each accepted word and retire it from the queue.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_column(in_tdata);
      void'(sample_queue.pop_front());
    end
  end

  // Driver: hold a waiting word; after a handshake or idle, offer the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (sample_queue.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= sample_queue[0];
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is pending.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted column word with the oldest prediction.
  always @(posedge clk) begin
    column_t got, exp_c;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.column_number = out_tdata[11:0];
      got.back_bar = out_tdata[19:12];
      got.front_bar = out_tdata[27:20];
      got.back_red = out_tdata[35:28];
      got.back_green = out_tdata[43:36];
      got.back_blue = out_tdata[51:44];
      got.front_red = out_tdata[59:52];
      got.front_green = out_tdata[67:60];
      got.front_blue = out_tdata[75:68];
      got.last_column = out_tlast;
      if (column_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column word %h", got);
      end else begin
        exp_c = column_queue.pop_front();
        if (got !== exp_c) begin
          mismatches++;
          if (mismatches <= 10) $display("column mismatch exp %h got %h", exp_c, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COLOR_MODE:    mode_q = val[0];
      REG_SAMPLE_COUNT:  nsamp_q = val[12:0];
      REG_COLUMN_COUNT:  ncol_q = val[12:0];
      REG_HEIGHT_PIXELS: height_q = val[7:0];
      REG_PEAK_LEVEL:    peak_q = val[7:0];
      default: ;
    endcase
    samp_pos = 0;
  endtask

  // Drain: wait for all words accepted and all columns seen, then settle.
  task automatic drain();
    while (sample_queue.size() != 0 || column_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: w = 32'h0;
      1: w = 32'hFFFF_FFFF;
      2: w[7:0] = {w[7:5], 5'h1F};
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_set(bit m, int unsigned ns, int unsigned nc, int unsigned h,
                         int unsigned p, int n);
    write_reg(REG_COLOR_MODE, m);
    write_reg(REG_SAMPLE_COUNT, ns);
    write_reg(REG_COLUMN_COUNT, nc);
    write_reg(REG_HEIGHT_PIXELS, h);
    write_reg(REG_PEAK_LEVEL, p);
    for (int i = 0; i < n; i++) sample_queue.push_back(rand_sample());
    drain();
  endtask

  initial begin
    int unsigned ns;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COLOR_MODE;
    cfg_data = '0;
    mismatches = 0;
    hold_cycles = 0;
    cycle_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 50;
    mode_q = 0; nsamp_q = 400; ncol_q = 400; height_q = 32; peak_q = 255;
    samp_pos = 0; col_pos = 0; bkt_end = 0; bkt_rem = 0;
    bkt_step = 0; bkt_extra = 0; loud_smp = 0; blue_smp = 0; bkt_open = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ties, class boundary, black rgb, saturated heights.
    run_set(0, 4, 4, 255, 1, 0);
    sample_queue.push_back(32'h9F); sample_queue.push_back(32'h80);
    sample_queue.push_back(32'hA0); sample_queue.push_back(32'hBF);
    drain();
    run_set(0, 6, 2, 1, 1, 0);
    sample_queue.push_back(32'h11); sample_queue.push_back(32'hF1);
    sample_queue.push_back(32'h05); sample_queue.push_back(32'hFF);
    sample_queue.push_back(32'h1F); sample_queue.push_back(32'h00);
    drain();
    run_set(1, 5, 2, 255, 1, 0);
    sample_queue.push_back(32'h0); sample_queue.push_back(32'h0);
    sample_queue.push_back(32'hFF01_0200); sample_queue.push_back(32'h0000_FF00);
    sample_queue.push_back(32'hFFFF_FF00);
    drain();
    // Invalid settings: samples are dropped.
    run_set(0, 3, 5, 10, 1, 4);
    run_set(1, 8, 4, 10, 0, 4);
    run_set(0, 0, 1, 10, 1, 3);
    run_set(0, 8, 4, 0, 1, 3);

    // Random phases across all idling regimes.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 50; recv_idle_pct = 9; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      ns = (ph == 5) ? 300 : $urandom_range(1, 60);
      if (ph == 2) hold_cycles = 3000;
      run_set($urandom_range(1), ns,
              (ph == 6) ? ns : ((ph == 5) ? 40 : $urandom_range(1, ns)),
              (ph == 3) ? 255 : $urandom_range(1, 255),
              (ph == 7) ? 1 : $urandom_range(1, 255),
              (ph == 5) ? 0 : 25);
      if (ph == 5) begin
        for (int i = 0; i < ns; i++) sample_queue.push_back(rand_sample());
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/wcd_pkg.sv
rtl/wcd_div.sv
rtl/waveform_column_downsample.sv
tb/tb_waveform_column_downsample.sv
